// ----- sv/tesd_pkg.sv -----
// Shared types, key codes and ground-state decode for the escape sequence decoder.
`default_nettype none
package tesd_pkg;

   localparam logic [2:0] KIND_KEY        = 3'd0;
   localparam logic [2:0] KIND_MOUSE_DOWN = 3'd1;
   localparam logic [2:0] KIND_MOUSE_UP   = 3'd2;
   localparam logic [2:0] KIND_WHEEL_UP   = 3'd3;
   localparam logic [2:0] KIND_WHEEL_DOWN = 3'd4;

   localparam logic [8:0] KEY_ENTER     = 9'd256;
   localparam logic [8:0] KEY_TAB       = 9'd257;
   localparam logic [8:0] KEY_BACKSPACE = 9'd258;
   localparam logic [8:0] KEY_ESCAPE    = 9'd259;
   localparam logic [8:0] KEY_UP        = 9'd260;
   localparam logic [8:0] KEY_DOWN      = 9'd261;
   localparam logic [8:0] KEY_RIGHT     = 9'd262;
   localparam logic [8:0] KEY_LEFT      = 9'd263;
   localparam logic [8:0] KEY_HOME      = 9'd264;
   localparam logic [8:0] KEY_END       = 9'd265;
   localparam logic [8:0] KEY_INSERT    = 9'd266;
   localparam logic [8:0] KEY_DELETE    = 9'd267;
   localparam logic [8:0] KEY_PAGE_UP   = 9'd268;
   localparam logic [8:0] KEY_PAGE_DOWN = 9'd269;
   localparam logic [8:0] KEY_F1        = 9'd270;
   localparam logic [8:0] KEY_F2        = 9'd271;
   localparam logic [8:0] KEY_F3        = 9'd272;
   localparam logic [8:0] KEY_F4        = 9'd273;

   localparam logic [7:0] CH_BEL   = 8'd7;
   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_ESC   = 8'd27;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_DEL   = 8'd127;

   typedef struct packed {
      logic [2:0]  kind;
      logic [8:0]  key;
      logic [3:0]  mods;
      logic [1:0]  btn;
      logic [15:0] col;
      logic [15:0] row;
   } event_type;

   typedef struct packed {
      logic      hit;
      event_type ev;
      logic      to_esc;
      logic      set_cr;
   } ground_type;

   function automatic event_type key_event(input logic [8:0] key, input logic [3:0] mods);
      event_type e;
      e = '0;
      e.kind = KIND_KEY;
      e.key  = key;
      e.mods = mods;
      return e;
   endfunction

   function automatic logic is_text(input event_type e);
      return (e.kind == KIND_KEY) && (e.key != 9'd0) && (e.key < KEY_ENTER) && (e.mods == 4'd0);
   endfunction

   // Decode one byte in ground; pend is a CR just seen, lwt the text-run flag.
   function automatic ground_type ground_decode(input logic [7:0] c, input logic pend,
                                                input logic lwt);
      ground_type g;
      g = '0;
      if (c >= CH_SPACE && c != CH_DEL) begin
         g.hit = !lwt;
         g.ev  = key_event({1'b0, c}, 4'd0);
      end else if (c == CH_CR) begin
         g.hit    = 1'b1;
         g.set_cr = 1'b1;
         g.ev     = key_event(KEY_ENTER, 4'd0);
      end else if (c == CH_LF) begin
         g.hit = !pend;
         g.ev  = key_event(KEY_ENTER, 4'd0);
      end else if (c == CH_TAB) begin
         g.hit = 1'b1;
         g.ev  = key_event(KEY_TAB, 4'd0);
      end else if (c == CH_BS || c == CH_DEL) begin
         g.hit = 1'b1;
         g.ev  = key_event(KEY_BACKSPACE, 4'd0);
      end else if (c == CH_ESC) begin
         g.to_esc = 1'b1;
      end
      return g;
   endfunction

endpackage
`default_nettype wire

// ----- sv/terminal_escape_sequence_decoder_core.sv -----
// Terminal escape sequence decoder: raw terminal bytes in, key and mouse events out.
//
// Request channel: req_valid / req_stall carry one raw byte per word (req_byte_in).
// A word is taken at a rising edge with req_valid high and req_stall low.
// Response channel: rsp_valid / rsp_stall carry one event per word; rsp_last_of_run
// marks the final event caused by a byte. A byte gives zero, one or two events.
// Each byte is decoded in the cycle it is taken: parser state updates at that
// edge and its events land in a four-word output queue, from which they are
// offered in order behind any older events. One byte is taken every cycle while
// the queue has room for two events; the queue depth sets that figure.
// When the receiver stalls, events wait in the queue and req_stall rises once
// fewer than two slots are free; no event is lost or repeated.
// Synchronous reset returns the parser to ground, clears the parameter count,
// the pending-CR and text-run flags, and empties the queue. Parameter values are
// not cleared: an entry is always written before it is read within a CSI.
`default_nettype none
module terminal_escape_sequence_decoder_core #(
   parameter int MAX_PARAMS = 8,
   parameter int PARAM_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_byte_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_event_kind,
   output logic [8:0]       rsp_key_code,
   output logic [3:0]       rsp_modifiers,
   output logic [1:0]       rsp_mouse_button,
   output logic [15:0]      rsp_mouse_col,
   output logic [15:0]      rsp_mouse_row,
   output logic             rsp_last_of_run
);

   localparam int CNT_W = $clog2(MAX_PARAMS + 1);
   localparam int IDX_W = $clog2(MAX_PARAMS);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARAMS);
   localparam logic [PARAM_BITS+3:0] SAT_LIMIT = {4'd0, {PARAM_BITS{1'b1}}};
   localparam logic [PARAM_BITS-1:0] P_2  = PARAM_BITS'(2);
   localparam logic [PARAM_BITS-1:0] P_3  = PARAM_BITS'(3);
   localparam logic [PARAM_BITS-1:0] P_5  = PARAM_BITS'(5);
   localparam logic [PARAM_BITS-1:0] P_6  = PARAM_BITS'(6);
   localparam logic [PARAM_BITS-1:0] P_11 = PARAM_BITS'(11);
   localparam logic [PARAM_BITS-1:0] P_34 = PARAM_BITS'(34);
   localparam logic [PARAM_BITS-1:0] P_64 = PARAM_BITS'(64);

   typedef enum logic [2:0] {
      MODE_GROUND, MODE_ESC, MODE_CSI, MODE_SS3, MODE_STR, MODE_STR_ESC
   } mode_type;

   typedef struct packed {
      tesd_pkg::event_type ev;
      logic                last;
   } word_type;

   // parser state
   mode_type               mode_ff, mode_in;
   logic [PARAM_BITS-1:0]  pv_ff [MAX_PARAMS];
   logic [PARAM_BITS-1:0]  pv_wdata;
   logic                   pv_we;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   digit_ff, digit_in;
   logic                   sgr_ff, sgr_in;
   logic                   cr_ff, cr_in;
   logic                   lwt_ff, lwt_in;

   // output queue
   word_type               q_ff [4];
   logic [1:0]             wr_ff, rd_ff;
   logic [2:0]             qcnt_ff;

   logic                   take, give;
   logic [IDX_W-1:0]       idx;
   logic                   cnt_lt;
   logic [PARAM_BITS-1:0]  cur, p0, p1, p2;
   logic [PARAM_BITS+3:0]  acc;
   logic [CNT_W-1:0]       n;
   tesd_pkg::ground_type   g;
   tesd_pkg::event_type    r0, r1, fin;
   logic                   r0_hit, r1_hit, fin_hit;
   logic [7:0]             c;
   logic [3:0]             mod_p1;

   function automatic logic [15:0] sat16(input logic [PARAM_BITS-1:0] v);
      logic [PARAM_BITS+15:0] w;
      w = {16'd0, v};
      if (w > (PARAM_BITS + 16)'(65535)) return 16'hFFFF;
      return w[15:0];
   endfunction

   assign take      = req_valid && !req_stall;
   assign give      = rsp_valid && !rsp_stall;
   assign req_stall = qcnt_ff > 3'd2;
   assign c         = req_byte_in;
   assign idx       = cnt_ff[IDX_W-1:0];
   assign cnt_lt    = cnt_ff < CNT_MAX;
   assign cur       = pv_ff[idx];

   // Saturating decimal accumulate for the open parameter.
   always_comb begin
      acc = ({4'd0, (digit_ff ? cur : '0)} << 3) + ({4'd0, (digit_ff ? cur : '0)} << 1)
            + (PARAM_BITS + 4)'(c - 8'h30);
   end

   // Parameters as seen after the closing push.
   always_comb begin
      n  = cnt_lt ? cnt_ff + CNT_W'(1) : cnt_ff;
      p0 = (cnt_lt && cnt_ff == CNT_W'(0) && !digit_ff) ? '0 : pv_ff[0];
      p1 = (cnt_lt && cnt_ff == CNT_W'(1) && !digit_ff) ? '0 : pv_ff[1];
      p2 = (cnt_lt && cnt_ff == CNT_W'(2) && !digit_ff) ? '0 : pv_ff[2];
      mod_p1 = (p1 >= P_2) ? (p1[3:0] - 4'd1) : 4'd0;
   end

   // Decode the CSI final byte.
   always_comb begin
      fin     = '0;
      fin_hit = 1'b0;
      if ((sgr_ff && n >= CNT_W'(3) && (c == "M" || c == "m")) ||
          (n >= CNT_W'(3) && p0 < P_64 && c == "M")) begin
         fin_hit = 1'b1;
         if (p0 >= P_64) fin.kind = p0[0] ? tesd_pkg::KIND_WHEEL_DOWN : tesd_pkg::KIND_WHEEL_UP;
         else fin.kind = (c == "m") ? tesd_pkg::KIND_MOUSE_UP : tesd_pkg::KIND_MOUSE_DOWN;
         fin.mods = {1'b0, p0[4], p0[3], p0[2]};
         fin.btn  = p0[1:0];
         fin.col  = sat16(p1);
         fin.row  = sat16(p2);
      end else if (c == "~") begin
         fin_hit = 1'b1;
         if (p0 == P_2) fin = tesd_pkg::key_event(tesd_pkg::KEY_INSERT, 4'd0);
         else if (p0 == P_3) fin = tesd_pkg::key_event(tesd_pkg::KEY_DELETE, 4'd0);
         else if (p0 == P_5) fin = tesd_pkg::key_event(tesd_pkg::KEY_PAGE_UP, 4'd0);
         else if (p0 == P_6) fin = tesd_pkg::key_event(tesd_pkg::KEY_PAGE_DOWN, 4'd0);
         else if (p0 >= P_11 && p0 <= P_34)
            fin = tesd_pkg::key_event(9'(p0[5:0]) + 9'd259, 4'd0);
         else fin_hit = 1'b0;
         fin.mods = (n >= CNT_W'(2)) ? mod_p1 : 4'd0;
      end else begin
         fin_hit = 1'b1;
         case (c)
            "A": fin = tesd_pkg::key_event(tesd_pkg::KEY_UP, 4'd0);
            "B": fin = tesd_pkg::key_event(tesd_pkg::KEY_DOWN, 4'd0);
            "C": fin = tesd_pkg::key_event(tesd_pkg::KEY_RIGHT, 4'd0);
            "D": fin = tesd_pkg::key_event(tesd_pkg::KEY_LEFT, 4'd0);
            "H": fin = tesd_pkg::key_event(tesd_pkg::KEY_HOME, 4'd0);
            "F": fin = tesd_pkg::key_event(tesd_pkg::KEY_END, 4'd0);
            "Z": fin = tesd_pkg::key_event(tesd_pkg::KEY_TAB, 4'd0);
            default: fin_hit = 1'b0;
         endcase
         if (n >= CNT_W'(2) && c >= "A" && c <= "D") fin.mods = mod_p1;
      end
   end

   // Main byte decode: next state and up to two events.
   always_comb begin
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      digit_in = digit_ff;
      sgr_in   = sgr_ff;
      cr_in    = 1'b0;
      pv_we    = 1'b0;
      pv_wdata = acc > SAT_LIMIT ? {PARAM_BITS{1'b1}} : acc[PARAM_BITS-1:0];
      r0       = '0;
      r1       = '0;
      r0_hit   = 1'b0;
      r1_hit   = 1'b0;
      g        = tesd_pkg::ground_decode(c, cr_ff, lwt_ff);
      unique case (mode_ff)
         MODE_ESC: begin
            mode_in = MODE_GROUND;
            if (c == tesd_pkg::CH_ESC) begin
               r0_hit = 1'b1;
               r0     = tesd_pkg::key_event(tesd_pkg::KEY_ESCAPE, 4'd0);
            end else if (c == "[") begin
               mode_in  = MODE_CSI;
               cnt_in   = '0;
               digit_in = 1'b0;
               sgr_in   = 1'b0;
            end else if (c == "O") begin
               mode_in = MODE_SS3;
            end else if (c == "]" || c == "P" || c == "X" || c == "^" || c == "_") begin
               mode_in = MODE_STR;
            end else begin
               // escape key first, then the byte as in ground with no run or CR
               g      = tesd_pkg::ground_decode(c, 1'b0, 1'b0);
               r0_hit = 1'b1;
               r0     = tesd_pkg::key_event(tesd_pkg::KEY_ESCAPE, 4'd0);
               r1_hit = g.hit;
               r1     = g.ev;
               cr_in  = g.set_cr;
               if (g.to_esc) mode_in = MODE_ESC;
            end
         end
         MODE_CSI: begin
            if (c >= "0" && c <= "9") begin
               if (cnt_lt) begin
                  pv_we    = 1'b1;
                  digit_in = 1'b1;
               end
            end else if (c == ";" ||
                         !(c == "<" && cnt_ff == '0 && !digit_ff && !sgr_ff)) begin
               // push the open parameter; an empty one reads as zero
               pv_wdata = '0;
               pv_we    = cnt_lt && !digit_ff;
               cnt_in   = n;
               digit_in = 1'b0;
               if (c != ";") begin
                  mode_in = MODE_GROUND;
                  r0_hit  = fin_hit;
                  r0      = fin;
               end
            end else begin
               sgr_in = 1'b1;
            end
         end
         MODE_SS3: begin
            mode_in = MODE_GROUND;
            r0_hit  = 1'b1;
            case (c)
               "P": r0 = tesd_pkg::key_event(tesd_pkg::KEY_F1, 4'd0);
               "Q": r0 = tesd_pkg::key_event(tesd_pkg::KEY_F2, 4'd0);
               "R": r0 = tesd_pkg::key_event(tesd_pkg::KEY_F3, 4'd0);
               "S": r0 = tesd_pkg::key_event(tesd_pkg::KEY_F4, 4'd0);
               "A": r0 = tesd_pkg::key_event(tesd_pkg::KEY_UP, 4'd0);
               "B": r0 = tesd_pkg::key_event(tesd_pkg::KEY_DOWN, 4'd0);
               "C": r0 = tesd_pkg::key_event(tesd_pkg::KEY_RIGHT, 4'd0);
               "D": r0 = tesd_pkg::key_event(tesd_pkg::KEY_LEFT, 4'd0);
               "H": r0 = tesd_pkg::key_event(tesd_pkg::KEY_HOME, 4'd0);
               "F": r0 = tesd_pkg::key_event(tesd_pkg::KEY_END, 4'd0);
               default: r0_hit = 1'b0;
            endcase
         end
         MODE_STR, MODE_STR_ESC: begin
            if (mode_ff == MODE_STR_ESC && c == "\\") mode_in = MODE_GROUND;
            else if (c == tesd_pkg::CH_ESC) mode_in = MODE_STR_ESC;
            else if (c == tesd_pkg::CH_BEL) mode_in = MODE_GROUND;
            else mode_in = MODE_STR;
         end
         default: begin
            mode_in = MODE_GROUND;
            r0_hit  = g.hit;
            r0      = g.ev;
            cr_in   = g.set_cr;
            if (g.to_esc) mode_in = MODE_ESC;
         end
      endcase
      // text-run flag follows the last event emitted; hold it otherwise
      if (r1_hit) lwt_in = tesd_pkg::is_text(r1);
      else if (r0_hit) lwt_in = tesd_pkg::is_text(r0);
      else lwt_in = lwt_ff;
   end

   // Parser state and parameter store.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_GROUND;
         cnt_ff   <= '0;
         digit_ff <= 1'b0;
         sgr_ff   <= 1'b0;
         cr_ff    <= 1'b0;
         lwt_ff   <= 1'b0;
      end else if (take) begin
         mode_ff  <= mode_in;
         cnt_ff   <= cnt_in;
         digit_ff <= digit_in;
         sgr_ff   <= sgr_in;
         cr_ff    <= cr_in;
         lwt_ff   <= lwt_in;
      end
      if (take && pv_we) pv_ff[idx] <= pv_wdata;
   end

   // Output queue: push up to two words, pop one.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         qcnt_ff <= '0;
      end else begin
         wr_ff   <= wr_ff + 2'((take && r0_hit) ? 1 : 0) + 2'((take && r1_hit) ? 1 : 0);
         rd_ff   <= rd_ff + 2'(give ? 1 : 0);
         qcnt_ff <= qcnt_ff + 3'((take && r0_hit) ? 1 : 0) + 3'((take && r1_hit) ? 1 : 0)
                    - 3'(give ? 1 : 0);
      end
      if (take && r0_hit) q_ff[wr_ff] <= '{ev: r0, last: !r1_hit};
      if (take && r1_hit) q_ff[wr_ff + 2'd1] <= '{ev: r1, last: 1'b1};
   end

   assign rsp_valid        = qcnt_ff != 3'd0;
   assign rsp_event_kind   = q_ff[rd_ff].ev.kind;
   assign rsp_key_code     = q_ff[rd_ff].ev.key;
   assign rsp_modifiers    = q_ff[rd_ff].ev.mods;
   assign rsp_mouse_button = q_ff[rd_ff].ev.btn;
   assign rsp_mouse_col    = q_ff[rd_ff].ev.col;
   assign rsp_mouse_row    = q_ff[rd_ff].ev.row;
   assign rsp_last_of_run  = q_ff[rd_ff].last;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff <= 3'd4) else $error("output queue overflow");
   a_queue_track: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff[1:0] == 2'(wr_ff - rd_ff)) else $error("queue pointers disagree with fill");
   a_second_last: assert property (@(posedge clock) disable iff (reset)
      (take && r1_hit) |-> r0_hit) else $error("second event without a first");
   a_param_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX) else $error("parameter count beyond limit");

endmodule
`default_nettype wire

// ----- bench/terminal_escape_sequence_decoder_checker.sv -----
// Watches both channels, predicts the event stream from the byte stream and compares.
module terminal_escape_sequence_decoder_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_byte_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_event_kind,
   input  logic [8:0]  rsp_key_code,
   input  logic [3:0]  rsp_modifiers,
   input  logic [1:0]  rsp_mouse_button,
   input  logic [15:0] rsp_mouse_col,
   input  logic [15:0] rsp_mouse_row,
   input  logic        rsp_last_of_run,
   output int          fail_count,
   output int          events_outstanding,
   output int          events_checked,
   output int          mouse_checked
);

   localparam int PARAM_SLOTS = 8;
   localparam int unsigned PARAM_CEIL = 65535;

   typedef enum logic [2:0] {
      PM_GROUND, PM_ESC, PM_CSI, PM_SS3, PM_STR, PM_STR_ESC
   } parse_mode_type;

   typedef struct {
      logic [2:0]  kind;
      logic [8:0]  key;
      logic [3:0]  mods;
      logic [1:0]  btn;
      logic [15:0] col;
      logic [15:0] row;
      logic        last;
   } term_event_type;

   parse_mode_type   mode;
   int unsigned      param_val [PARAM_SLOTS];
   int unsigned      param_num;
   bit               digit_flag;
   bit               sgr_flag;
   bit               cr_flag;
   bit               text_run;
   term_event_type   event_batch[$];
   term_event_type   expected_events[$];

   function automatic void emit(logic [2:0] kind, logic [8:0] key, logic [3:0] mods,
                                logic [1:0] btn, int unsigned col, int unsigned row);
      term_event_type e;
      e.kind = kind;
      e.key  = key;
      e.mods = mods;
      e.btn  = btn;
      e.col  = (col > PARAM_CEIL) ? 16'hFFFF : col[15:0];
      e.row  = (row > PARAM_CEIL) ? 16'hFFFF : row[15:0];
      e.last = 1'b0;
      event_batch.push_back(e);
      text_run = (kind == tesd_pkg::KIND_KEY) && (key != 9'd0) &&
                 (key < tesd_pkg::KEY_ENTER) && (mods == 4'd0);
   endfunction

   function automatic void emit_key(logic [8:0] key, logic [3:0] mods);
      emit(tesd_pkg::KIND_KEY, key, mods, 2'd0, 0, 0);
   endfunction

   function automatic logic [3:0] modifier_bits(int unsigned m);
      int unsigned v;
      v = m - 1;
      return (m >= 2) ? v[3:0] : 4'd0;
   endfunction

   function automatic void decode_ground(logic [7:0] c, bit pend);
      if (c >= tesd_pkg::CH_SPACE && c != tesd_pkg::CH_DEL) begin
         if (!text_run) emit_key({1'b0, c}, 4'd0);
      end else if (c == tesd_pkg::CH_CR) begin
         cr_flag = 1'b1;
         emit_key(tesd_pkg::KEY_ENTER, 4'd0);
      end else if (c == tesd_pkg::CH_LF) begin
         if (!pend) emit_key(tesd_pkg::KEY_ENTER, 4'd0);
      end else if (c == tesd_pkg::CH_TAB) begin
         emit_key(tesd_pkg::KEY_TAB, 4'd0);
      end else if (c == tesd_pkg::CH_BS || c == tesd_pkg::CH_DEL) begin
         emit_key(tesd_pkg::KEY_BACKSPACE, 4'd0);
      end else if (c == tesd_pkg::CH_ESC) begin
         mode = PM_ESC;
      end
   endfunction

   function automatic void close_param();
      if (param_num < PARAM_SLOTS) begin
         if (!digit_flag) param_val[param_num] = 0;
         param_num++;
      end
      digit_flag = 1'b0;
   endfunction

   function automatic void finish_csi(logic [7:0] t);
      int unsigned p0, p1, p2;
      logic [3:0]  mods;
      logic [2:0]  kind;
      close_param();
      p0 = (param_num > 0) ? param_val[0] : 0;
      p1 = (param_num > 1) ? param_val[1] : 0;
      p2 = (param_num > 2) ? param_val[2] : 0;
      if ((sgr_flag && param_num >= 3 && (t == "M" || t == "m")) ||
          (param_num >= 3 && p0 < 64 && t == "M")) begin
         if (p0 >= 64) kind = p0[0] ? tesd_pkg::KIND_WHEEL_DOWN : tesd_pkg::KIND_WHEEL_UP;
         else          kind = (t == "m") ? tesd_pkg::KIND_MOUSE_UP : tesd_pkg::KIND_MOUSE_DOWN;
         mods = {1'b0, p0[4], p0[3], p0[2]};
         emit(kind, 9'd0, mods, p0[1:0], p1, p2);
      end else if (t == "~") begin
         mods = (param_num >= 2) ? modifier_bits(p1) : 4'd0;
         if      (p0 == 2) emit_key(tesd_pkg::KEY_INSERT, mods);
         else if (p0 == 3) emit_key(tesd_pkg::KEY_DELETE, mods);
         else if (p0 == 5) emit_key(tesd_pkg::KEY_PAGE_UP, mods);
         else if (p0 == 6) emit_key(tesd_pkg::KEY_PAGE_DOWN, mods);
         else if (p0 >= 11 && p0 <= 34) emit_key(tesd_pkg::KEY_F1 + 9'(p0 - 11), mods);
      end else begin
         mods = (param_num >= 2 && t >= "A" && t <= "D") ? modifier_bits(p1) : 4'd0;
         case (t)
            "A": emit_key(tesd_pkg::KEY_UP, mods);
            "B": emit_key(tesd_pkg::KEY_DOWN, mods);
            "C": emit_key(tesd_pkg::KEY_RIGHT, mods);
            "D": emit_key(tesd_pkg::KEY_LEFT, mods);
            "H": emit_key(tesd_pkg::KEY_HOME, 4'd0);
            "F": emit_key(tesd_pkg::KEY_END, 4'd0);
            "Z": emit_key(tesd_pkg::KEY_TAB, 4'd0);
            default: ;
         endcase
      end
   endfunction

   function automatic void finish_ss3(logic [7:0] t);
      case (t)
         "P": emit_key(tesd_pkg::KEY_F1, 4'd0);
         "Q": emit_key(tesd_pkg::KEY_F2, 4'd0);
         "R": emit_key(tesd_pkg::KEY_F3, 4'd0);
         "S": emit_key(tesd_pkg::KEY_F4, 4'd0);
         "A": emit_key(tesd_pkg::KEY_UP, 4'd0);
         "B": emit_key(tesd_pkg::KEY_DOWN, 4'd0);
         "C": emit_key(tesd_pkg::KEY_RIGHT, 4'd0);
         "D": emit_key(tesd_pkg::KEY_LEFT, 4'd0);
         "H": emit_key(tesd_pkg::KEY_HOME, 4'd0);
         "F": emit_key(tesd_pkg::KEY_END, 4'd0);
         default: ;
      endcase
   endfunction

   // Advance the parser by one byte and queue the events it gives.
   function automatic void predict_byte(logic [7:0] c);
      bit          pend;
      int unsigned v;
      pend = cr_flag;
      cr_flag = 1'b0;
      event_batch.delete();
      case (mode)
         PM_ESC: begin
            mode = PM_GROUND;
            if (c == tesd_pkg::CH_ESC) begin
               emit_key(tesd_pkg::KEY_ESCAPE, 4'd0);
            end else if (c == "[") begin
               mode = PM_CSI;
               param_num = 0;
               digit_flag = 1'b0;
               sgr_flag = 1'b0;
            end else if (c == "O") begin
               mode = PM_SS3;
            end else if (c == "]" || c == "P" || c == "X" || c == "^" || c == "_") begin
               mode = PM_STR;
            end else begin
               emit_key(tesd_pkg::KEY_ESCAPE, 4'd0);
               decode_ground(c, 1'b0);
            end
         end
         PM_CSI: begin
            if (c >= "0" && c <= "9") begin
               if (param_num < PARAM_SLOTS) begin
                  v = digit_flag ? param_val[param_num] : 0;
                  v = v * 10 + (c - "0");
                  param_val[param_num] = (v > PARAM_CEIL) ? PARAM_CEIL : v;
                  digit_flag = 1'b1;
               end
            end else if (c == ";") begin
               close_param();
            end else if (c == "<" && param_num == 0 && !digit_flag && !sgr_flag) begin
               sgr_flag = 1'b1;
            end else begin
               mode = PM_GROUND;
               finish_csi(c);
            end
         end
         PM_SS3: begin
            mode = PM_GROUND;
            finish_ss3(c);
         end
         PM_STR, PM_STR_ESC: begin
            if (mode == PM_STR_ESC && c == "\\")  mode = PM_GROUND;
            else if (c == tesd_pkg::CH_ESC)      mode = PM_STR_ESC;
            else if (c == tesd_pkg::CH_BEL)      mode = PM_GROUND;
            else                                 mode = PM_STR;
         end
         default: begin
            mode = PM_GROUND;
            decode_ground(c, pend);
         end
      endcase
      if (event_batch.size() > 0) event_batch[event_batch.size() - 1].last = 1'b1;
      foreach (event_batch[i]) expected_events.push_back(event_batch[i]);
   endfunction

   function automatic void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      end
   endfunction

   always @(posedge clock) begin
      term_event_type e;
      if (reset) begin
         mode = PM_GROUND;
         param_num = 0;
         digit_flag = 1'b0;
         sgr_flag = 1'b0;
         cr_flag = 1'b0;
         text_run = 1'b0;
         expected_events.delete();
      end else begin
         // compare first: an event taken now was caused by an earlier byte
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected event, kind %0d key %0d", $time,
                        rsp_event_kind, rsp_key_code);
            end else begin
               e = expected_events.pop_front();
               compare_field("event_kind", e.kind, rsp_event_kind);
               compare_field("key_code", e.key, rsp_key_code);
               compare_field("modifiers", e.mods, rsp_modifiers);
               compare_field("mouse_button", e.btn, rsp_mouse_button);
               compare_field("mouse_col", e.col, rsp_mouse_col);
               compare_field("mouse_row", e.row, rsp_mouse_row);
               compare_field("last_of_run", e.last, rsp_last_of_run);
               events_checked++;
               if (e.kind != tesd_pkg::KIND_KEY) mouse_checked++;
            end
         end
         if (req_valid && !req_stall) predict_byte(req_byte_in);
      end
      events_outstanding = expected_events.size();
   end

   initial begin
      fail_count = 0;
      events_outstanding = 0;
      events_checked = 0;
      mouse_checked = 0;
   end

endmodule

// ----- bench/terminal_escape_sequence_decoder_core_test.sv -----
// Top of the decoder bench: clock, reset, byte stimulus, receiver stalls and verdict.
module terminal_escape_sequence_decoder_core_test;

   localparam int IDLE_LIMIT   = 5000;   // cycles with no word moving before giving up
   localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
   localparam int RANDOM_BYTES = 1600;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_byte_in;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_event_kind;
   logic [8:0]  rsp_key_code;
   logic [3:0]  rsp_modifiers;
   logic [1:0]  rsp_mouse_button;
   logic [15:0] rsp_mouse_col;
   logic [15:0] rsp_mouse_row;
   logic        rsp_last_of_run;

   int fail_count;
   int events_outstanding;
   int events_checked;
   int mouse_checked;

   int  send_idle_pct;
   int  recv_idle_pct;
   bit  hold_request;
   int  bytes_sent;
   int  quiet_cycles;

   terminal_escape_sequence_decoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_in      (req_byte_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_key_code     (rsp_key_code),
      .rsp_modifiers    (rsp_modifiers),
      .rsp_mouse_button (rsp_mouse_button),
      .rsp_mouse_col    (rsp_mouse_col),
      .rsp_mouse_row    (rsp_mouse_row),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   terminal_escape_sequence_decoder_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_in        (req_byte_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_key_code       (rsp_key_code),
      .rsp_modifiers      (rsp_modifiers),
      .rsp_mouse_button   (rsp_mouse_button),
      .rsp_mouse_col      (rsp_mouse_col),
      .rsp_mouse_row      (rsp_mouse_row),
      .rsp_last_of_run    (rsp_last_of_run),
      .fail_count         (fail_count),
      .events_outstanding (events_outstanding),
      .events_checked     (events_checked),
      .mouse_checked      (mouse_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: random stalls, or a long hold-off counted here once requested.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b1;
      forever begin
         @(posedge clock);
         if (hold_request && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Watchdog: end the run when no word moves on either channel for too long.
   initial begin : watchdog
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Offer one byte and hold it until taken; idle first at the sender's rate.
   task automatic send_byte(input logic [7:0] b);
      bit taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // Drop the valid and wait until every predicted event has come out.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (events_outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mostly short numbers, now and then one long enough to saturate.
   function automatic string random_number();
      case ($urandom_range(9))
         0:       return "";
         1:       return $sformatf("%0d", $urandom_range(99999, 65530));
         2:       return $sformatf("%0d", $urandom());
         3, 4:    return $sformatf("%0d", $urandom_range(40, 11));
         default: return $sformatf("%0d", $urandom_range(9));
      endcase
   endfunction

   function automatic logic [7:0] random_final();
      string finals;
      finals = "ABCDHFZ~Mm<xq";
      if ($urandom_range(7) == 0) return 8'($urandom_range(255));
      return finals[$urandom_range(finals.len() - 1)];
   endfunction

   // One random stretch of the stream: mostly well-formed sequences with random content.
   task automatic send_random_sequence();
      string s;
      int    n;
      case ($urandom_range(19))
         0, 1, 2: begin
            n = $urandom_range(6, 1);
            for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255, 32)));
         end
         3: send_byte($urandom_range(1) ? tesd_pkg::CH_CR : tesd_pkg::CH_LF);
         4: send_byte(8'($urandom_range(255)));
         5: send_byte(8'($urandom_range(31)));
         6, 7, 8, 9: begin
            s = {8'(tesd_pkg::CH_ESC), "["};
            if ($urandom_range(4) == 0) s = {s, "<"};
            n = $urandom_range(10);
            for (int i = 0; i < n; i++) begin
               s = {s, random_number()};
               if (i < n - 1) s = {s, ";"};
            end
            send_text(s);
            send_byte(random_final());
         end
         10, 11: begin
            s = {8'(tesd_pkg::CH_ESC), "["};
            if ($urandom_range(1)) s = {s, "<"};
            s = {s, $sformatf("%0d;%s;%s", $urandom_range(127), random_number(),
                              random_number())};
            send_text(s);
            send_byte($urandom_range(1) ? "M" : "m");
         end
         12, 13: begin
            send_byte(tesd_pkg::CH_ESC);
            send_byte("O");
            send_byte($urandom_range(3) == 0 ? 8'($urandom_range(255)) : random_final());
         end
         14: begin
            s = "]PX^_";
            send_byte(tesd_pkg::CH_ESC);
            send_byte(s[$urandom_range(4)]);
            n = $urandom_range(5);
            for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)));
            if ($urandom_range(1)) send_byte(tesd_pkg::CH_BEL);
            else begin
               send_byte(tesd_pkg::CH_ESC);
               send_byte("\\");
            end
         end
         15, 16: begin
            send_byte(tesd_pkg::CH_ESC);
            send_byte(8'($urandom_range(255)));
         end
         default: send_byte($urandom_range(1) ? tesd_pkg::CH_TAB : tesd_pkg::CH_DEL);
      endcase
   endtask

   initial begin : stimulus
      int phase_goal;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_byte_in   = 8'd0;
      hold_request  = 1'b0;
      bytes_sent    = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: text runs, editing keys, escape forms, CSI, mouse, SS3, strings
      send_text("ab ");
      send_byte(8'd255);
      send_byte(tesd_pkg::CH_CR);
      send_byte(tesd_pkg::CH_LF);
      send_byte(tesd_pkg::CH_LF);
      send_byte(tesd_pkg::CH_TAB);
      send_byte(tesd_pkg::CH_BS);
      send_byte(tesd_pkg::CH_DEL);
      send_byte(8'd1);
      send_text({8'(tesd_pkg::CH_ESC), 8'(tesd_pkg::CH_ESC), 8'(tesd_pkg::CH_ESC), "x"});
      send_text({8'(tesd_pkg::CH_ESC), "[1;5A", 8'(tesd_pkg::CH_ESC), "[3~",
                 8'(tesd_pkg::CH_ESC), "[34;16~"});
      send_text({8'(tesd_pkg::CH_ESC), "[99999;2D", 8'(tesd_pkg::CH_ESC), "[Z",
                 8'(tesd_pkg::CH_ESC), "[<0;10;20M"});
      send_text({8'(tesd_pkg::CH_ESC), "[<65;70000;1m", 8'(tesd_pkg::CH_ESC), "[32;5;6M"});
      send_text({8'(tesd_pkg::CH_ESC), "[1;2;3;4;5;6;7;8;9;10H",
                 8'(tesd_pkg::CH_ESC), "[1<"});
      send_text({8'(tesd_pkg::CH_ESC), "OP", 8'(tesd_pkg::CH_ESC), "O",
                 8'(tesd_pkg::CH_ESC), "a"});
      send_text({8'(tesd_pkg::CH_ESC), "]title", 8'(tesd_pkg::CH_BEL),
                 8'(tesd_pkg::CH_ESC), "Pq", 8'(tesd_pkg::CH_ESC), "\\", "z"});
      drain();

      // two idling phases, then a fill-up under a long receiver hold-off
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 58 : 0;
         recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 34 : 0;
         phase_goal = bytes_sent + RANDOM_BYTES / 3;
         if (phase == 2) hold_request = 1'b1;
         while (bytes_sent < phase_goal) send_random_sequence();
         drain();
      end

      // wait out the tail
      while (events_outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Covered %0d bytes, %0d events checked (%0d mouse), three stall mixes",
               bytes_sent, events_checked, mouse_checked);
      $display("plus a long receiver hold-off with the input backed up.");
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
